// ===== rtl/rpd_pkg.sv =====
package rpd_pkg;

  localparam int MAX_RECORDS = 16;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] HDR_BYTES   = 8'd3;
  localparam logic [7:0] POS_MAX     = 8'd255;
  localparam logic [7:0] VERSION_RST = 8'd1;
  localparam logic [7:0] COUNT_CAP   = 8'd31;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_SHORT_HDR = 3'd1,
    ERR_VERSION   = 3'd2,
    ERR_COUNT     = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    OFF_CHAN = 3'd0,
    OFF_B0   = 3'd1,
    OFF_B1   = 3'd2,
    OFF_B2   = 3'd3,
    OFF_B3   = 3'd4
  } rec_off_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  channel;
    logic [31:0] reading_bits;
    logic [7:0]  hdr_status;
    logic [4:0]  record_count;
    err_t        error_code;
    logic        end_of_frame;
  } res_t;

  typedef struct packed {
    logic rec_vld;
    logic sum_vld;
  } emit_t;

endpackage

// ===== rtl/rpd_parser.sv =====
module rpd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       frame_byte,
  input  logic             final_byte,
  input  logic [7:0]       expected_version,
  output rpd_pkg::emit_t   emit,
  output rpd_pkg::res_t    rec_res,
  output rpd_pkg::res_t    sum_res
);

  logic [7:0]        pos_r, pos_nxt;
  logic              vgood_r, vgood_nxt;
  logic [7:0]        status_r, status_nxt;
  logic [7:0]        count_r, count_nxt;
  logic [7:0]        chan_r, chan_nxt;
  logic [31:0]       gather_r, gather_nxt;
  logic [4:0]        seen_r, seen_nxt;
  rpd_pkg::rec_off_t off_r, off_nxt;
  logic [5:0]        rec_r, rec_nxt;

  logic              in_body;
  logic              gate;
  logic              vgood_c;
  logic [7:0]        status_c, count_c, chan_c;
  logic [31:0]       gather_c;
  logic [4:0]        seen_c;
  rpd_pkg::err_t     err_c;

  always_comb begin
    vgood_c  = (pos_r == 8'd0) ? (frame_byte == expected_version) : vgood_r;
    status_c = (pos_r == 8'd1) ? frame_byte : status_r;
    count_c  = (pos_r == 8'd2) ? frame_byte : count_r;

    in_body = (pos_r >= rpd_pkg::HDR_BYTES) && (pos_r != rpd_pkg::POS_MAX);
    gate    = in_body && vgood_r && (count_r <= 8'(rpd_pkg::MAX_RECORDS)) &&
              ({2'b00, rec_r} < count_r);

    chan_c   = chan_r;
    gather_c = gather_r;
    if (gate) begin
      unique case (off_r)
        rpd_pkg::OFF_CHAN: chan_c = frame_byte;
        rpd_pkg::OFF_B0:   gather_c = {24'd0, frame_byte};
        rpd_pkg::OFF_B1:   gather_c[15:8]  = frame_byte;
        rpd_pkg::OFF_B2:   gather_c[23:16] = frame_byte;
        rpd_pkg::OFF_B3:   gather_c[31:24] = frame_byte;
        default:           gather_c = gather_r;
      endcase
    end

    emit.rec_vld = step && gate && (off_r == rpd_pkg::OFF_B3);
    emit.sum_vld = step && final_byte;
    seen_c = seen_r + {4'd0, emit.rec_vld};

    if (pos_r < 8'd2) begin
      err_c = rpd_pkg::ERR_SHORT_HDR;
    end else if (!vgood_c) begin
      err_c = rpd_pkg::ERR_VERSION;
    end else if (count_c > 8'(rpd_pkg::MAX_RECORDS)) begin
      err_c = rpd_pkg::ERR_COUNT;
    end else if ({3'd0, seen_c} < count_c) begin
      err_c = rpd_pkg::ERR_TRUNCATED;
    end else begin
      err_c = rpd_pkg::ERR_OK;
    end

    rec_res.kind          = rpd_pkg::KIND_RECORD;
    rec_res.channel       = chan_r;
    rec_res.reading_bits  = gather_c;
    rec_res.hdr_status    = 8'd0;
    rec_res.record_count  = 5'd0;
    rec_res.error_code    = rpd_pkg::ERR_OK;
    rec_res.end_of_frame  = 1'b0;

    sum_res.kind          = rpd_pkg::KIND_SUMMARY;
    sum_res.channel       = 8'd0;
    sum_res.reading_bits  = 32'd0;
    sum_res.hdr_status    = status_c;
    sum_res.record_count  = (count_c > rpd_pkg::COUNT_CAP) ? 5'd31 : count_c[4:0];
    sum_res.error_code    = err_c;
    sum_res.end_of_frame  = 1'b1;
  end

  always_comb begin
    pos_nxt    = pos_r;
    vgood_nxt  = vgood_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    chan_nxt   = chan_r;
    gather_nxt = gather_r;
    seen_nxt   = seen_r;
    off_nxt    = off_r;
    rec_nxt    = rec_r;
    if (step) begin
      if (final_byte) begin
        pos_nxt    = 8'd0;
        vgood_nxt  = 1'b0;
        status_nxt = 8'd0;
        count_nxt  = 8'd0;
        chan_nxt   = 8'd0;
        gather_nxt = 32'd0;
        seen_nxt   = 5'd0;
        off_nxt    = rpd_pkg::OFF_CHAN;
        rec_nxt    = 6'd0;
      end else begin
        if (pos_r != rpd_pkg::POS_MAX) begin
          pos_nxt = pos_r + 8'd1;
        end
        vgood_nxt  = vgood_c;
        status_nxt = status_c;
        count_nxt  = count_c;
        chan_nxt   = chan_c;
        gather_nxt = gather_c;
        seen_nxt   = seen_c;
        if (in_body) begin
          if (off_r == rpd_pkg::OFF_B3) begin
            off_nxt = rpd_pkg::OFF_CHAN;
            rec_nxt = rec_r + 6'd1;
          end else begin
            off_nxt = rpd_pkg::rec_off_t'(off_r + 3'd1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 8'd0;
      vgood_r  <= 1'b0;
      status_r <= 8'd0;
      count_r  <= 8'd0;
      chan_r   <= 8'd0;
      gather_r <= 32'd0;
      seen_r   <= 5'd0;
      off_r    <= rpd_pkg::OFF_CHAN;
      rec_r    <= 6'd0;
    end else begin
      pos_r    <= pos_nxt;
      vgood_r  <= vgood_nxt;
      status_r <= status_nxt;
      count_r  <= count_nxt;
      chan_r   <= chan_nxt;
      gather_r <= gather_nxt;
      seen_r   <= seen_nxt;
      off_r    <= off_nxt;
      rec_r    <= rec_nxt;
    end
  end

endmodule

// ===== rtl/reading_payload_deframer_top.sv =====
// Measurement frame deframer. Feed one frame byte per transfer on in_, with
// in_tlast on the frame's final byte. Each complete five-byte record (channel,
// then float bits LSB first) within the declared count comes out on out_ with
// out_tuser low; the final byte also produces a summary (out_tuser and
// out_tlast high) with status, count (capped at 31) and an error code, after
// the record it may complete. A byte is held in the input register and passes
// through the parser into a four-entry result queue; one byte is taken every
// cycle while the queue has room for two results, and the single output port
// drains one result per cycle while out_tready is high. expected_version is
// written through cfg_we/cfg_wdata; the user must write it only while the
// block is idle, since the block itself does not enforce this.
module reading_payload_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] channel, [39:8] reading_bits,
                                  // [47:40] hdr_status, [52:48] record_count,
                                  // [55:53] error_code
  output logic        out_tuser,  // result_kind
  output logic        out_tlast,  // end_of_frame
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata   // expected_version
);

  logic [7:0] ver_r;
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  logic                        room;
  logic                        fire;
  logic                        in_acc;
  logic                        pop;
  rpd_pkg::emit_t              emit;
  rpd_pkg::res_t               rec_res, sum_res, head;
  rpd_pkg::res_t               q_r [rpd_pkg::FIFO_DEPTH];
  logic [rpd_pkg::FIFO_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_2nd;
  logic [rpd_pkg::FIFO_CW-1:0] cnt_r, cnt_nxt;

  assign room      = cnt_r <= rpd_pkg::FIFO_CW'(rpd_pkg::FIFO_DEPTH - 2);
  assign fire      = in_vld_r && room;
  assign in_tready = !in_vld_r || room;
  assign in_acc    = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r    <= rpd_pkg::VERSION_RST;
      in_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ver_r <= cfg_wdata;
      end
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  rpd_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (fire),
    .frame_byte       (in_byte_r),
    .final_byte       (in_last_r),
    .expected_version (ver_r),
    .emit             (emit),
    .rec_res          (rec_res),
    .sum_res          (sum_res)
  );

  always_comb begin
    wp_2nd  = wp_r + rpd_pkg::FIFO_AW'(emit.rec_vld);
    wp_nxt  = wp_2nd + rpd_pkg::FIFO_AW'(emit.sum_vld);
    rp_nxt  = rp_r + rpd_pkg::FIFO_AW'(pop);
    cnt_nxt = cnt_r + rpd_pkg::FIFO_CW'(emit.rec_vld) + rpd_pkg::FIFO_CW'(emit.sum_vld)
              - rpd_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.rec_vld) begin
      q_r[wp_r] <= rec_res;
    end
    if (emit.sum_vld) begin
      q_r[wp_2nd] <= sum_res;
    end
  end

  assign head       = q_r[rp_r];
  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = {head.error_code, head.record_count, head.hdr_status,
                       head.reading_bits, head.channel};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.end_of_frame;

endmodule

// ===== rtl/rpd_checker.sv =====
module rpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == out_tlast)
    else $error("summary kind and end marker disagree");

  a_rec_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == rpd_pkg::KIND_RECORD |-> out_tdata[55:40] == 16'd0)
    else $error("record carries summary fields");

  a_sum_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == rpd_pkg::KIND_SUMMARY |->
      out_tdata[39:0] == 40'd0 && out_tdata[55:53] <= rpd_pkg::ERR_TRUNCATED)
    else $error("summary carries record fields or bad error code");

endmodule

bind reading_payload_deframer_top rpd_checker u_rpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
